// ===== src/cre_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types, constants and tables for the clock ratio estimator.
package cre_pkg;

	localparam int HISTORY_DEPTH_DEF = 10;
	localparam int CFG_IDX_W         = 1;
	localparam int CFG_DATA_W        = 10;
	localparam int DEN_W             = 50;
	localparam int QUO_W             = 32;
	localparam int STEP_W            = 6;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 1'b1;

	localparam logic [9:0]  INTERVAL_RST = 10'd100;
	localparam logic [7:0]  SETTLE_RST   = 8'd10;
	localparam logic [31:0] RATIO_ONE    = 32'h0100_0000;
	localparam logic [31:0] RATIO_MAX    = 32'hFFFF_FFFF;
	localparam logic [17:0] RECIP_1000   = 18'd134218;
	localparam logic [STEP_W-1:0] RATIO_STEPS = 6'd32;
	localparam logic [STEP_W-1:0] MOD_STEPS   = 6'd20;

	typedef struct packed {
		logic [5:0]  wall_sec;
		logic [9:0]  wall_msec;
		logic [27:0] delta_time;
	} tick_t;

	typedef struct packed {
		logic [31:0] factor;
		logic        sample_taken;
		logic        factor_updated;
	} result_t;

	typedef struct packed {
		logic accept;
		logic acc;
		logic wq;
		logic shift;
		logic devm;
		logic deva;
		logic decide;
		logic div_ratio;
		logic div_mod;
		logic ratio_load;
		logic mod_load;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic primed;
		logic sample_hit;
		logic dev_last;
		logic need_div;
		logic div_done;
	} sts_t;

	typedef struct packed {
		logic              start;
		logic [DEN_W-1:0]  den;
		logic [DEN_W-1:0]  r_init;
		logic [QUO_W-1:0]  dividend;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
		logic [DEN_W-1:0] rem;
	} div_rsp_t;

	// ceil(2^20 / k), exact floor division of 16-bit values by k
	function automatic logic [20:0] recip(input logic [3:0] k);
		logic [20:0] r;
		case (k)
			4'd1:    r = 21'd1048576;
			4'd2:    r = 21'd524288;
			4'd3:    r = 21'd349526;
			4'd4:    r = 21'd262144;
			4'd5:    r = 21'd209716;
			4'd6:    r = 21'd174763;
			4'd7:    r = 21'd149797;
			4'd8:    r = 21'd131072;
			4'd9:    r = 21'd116509;
			4'd10:   r = 21'd104858;
			4'd11:   r = 21'd95326;
			4'd12:   r = 21'd87382;
			4'd13:   r = 21'd80660;
			4'd14:   r = 21'd74899;
			4'd15:   r = 21'd69906;
			default: r = 21'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/cre_stream_if.sv =====
`timescale 1ns / 1ps
// Interface: valid/ready stream channel carrying one item.
interface cre_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/cre_div.sv =====
`timescale 1ns / 1ps
// Shared restoring divider: one quotient bit per cycle.
module cre_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cre_pkg::div_req_t req,
	output cre_pkg::div_rsp_t rsp
);

	logic [cre_pkg::DEN_W-1:0]  den_q;
	logic [cre_pkg::DEN_W-1:0]  r_q;
	logic [cre_pkg::QUO_W-1:0]  dvd_q;
	logic [cre_pkg::QUO_W-1:0]  quo_q;
	logic [cre_pkg::STEP_W-1:0] cnt_q;
	logic [cre_pkg::DEN_W:0]    rs;
	logic [cre_pkg::DEN_W:0]    diffv;
	logic                       ge;

	always_comb begin
		rs    = {r_q, dvd_q[cre_pkg::QUO_W-1]};
		diffv = rs - {1'b0, den_q};
		ge    = rs >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= req.steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			r_q   <= req.r_init;
			dvd_q <= req.dividend;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			r_q   <= ge ? diffv[cre_pkg::DEN_W-1:0] : rs[cre_pkg::DEN_W-1:0];
			quo_q <= {quo_q[cre_pkg::QUO_W-2:0], ge};
			dvd_q <= {dvd_q[cre_pkg::QUO_W-2:0], 1'b0};
		end
	end

	assign rsp.done = (cnt_q == '0);
	assign rsp.quo  = quo_q;
	assign rsp.rem  = r_q;

endmodule

// ===== src/cre_dp.sv =====
`timescale 1ns / 1ps
// Datapath: accumulators, histories, deviation sum, factor and output register.
module cre_dp #(
	parameter int HISTORY_DEPTH = cre_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cre_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cre_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  cre_pkg::tick_t                  tick_data,
	input  cre_pkg::cmd_t                   cmd,
	output cre_pkg::sts_t                   sts,
	output cre_pkg::result_t                result_data
);

	localparam int KW    = $clog2(HISTORY_DEPTH);
	localparam int DEV_W = 16 + KW;
	localparam int LAST  = HISTORY_DEPTH - 1;
	localparam int PREV  = HISTORY_DEPTH - 2;

	logic [9:0]              interval_q;
	logic [7:0]              settle_left_q;
	cre_pkg::tick_t          in_q;
	logic                    primed_q;
	logic [5:0]              prev_sec_q;
	logic [9:0]              prev_msec_q;
	logic signed [19:0]      ms_accum_q;
	logic [31:0]             local_accum_q;
	logic [15:0]             wh_q [HISTORY_DEPTH];
	logic [39:0]             lh_q [HISTORY_DEPTH];
	logic [31:0]             ratio_q;
	logic                    sampled_q;
	logic                    updated_q;
	logic [34:0]             wprod_s1;
	logic                    wneed_q;
	logic [KW-1:0]           kcnt_q;
	logic [36:0]             dprod_s1;
	logic [DEV_W-1:0]        dev_q;
	logic [49:0]             den_q;
	cre_pkg::result_t        out_q;

	logic [9:0]              ivl;
	logic signed [7:0]       dsec, d1, d2;
	logic [5:0]              ds;
	logic [15:0]             ds_k;
	logic signed [17:0]      step;
	logic signed [21:0]      msum;
	logic signed [19:0]      ms_next;
	logic [32:0]             lsum;
	logic [15:0]             wdiff;
	logic [16:0]             wx;
	logic [7:0]              wq8;
	logic [17:0]             wadd;
	logic [17:0]             w0;
	logic [15:0]             wsub;
	logic [39:0]             lbase;
	logic [KW-1:0]           idx;
	logic [15:0]             span_a;
	logic [15:0]             avg;
	logic [15:0]             adev;
	logic [15:0]             wspan;
	logic [39:0]             lspan;
	logic                    dev_ok;
	logic                    sat_hit;
	cre_pkg::div_req_t       dreq;
	cre_pkg::div_rsp_t       drsp;

	assign ivl = (interval_q == '0) ? 10'd1 : interval_q;

	always_comb begin
		dsec  = $signed({2'b0, in_q.wall_sec}) - $signed({2'b0, prev_sec_q});
		d1    = (dsec < 0) ? dsec + 8'sd60 : dsec;
		d2    = (d1 < 0) ? d1 + 8'sd60 : d1;
		ds    = (d2 >= 8'sd60) ? 6'(d2 - 8'sd60) : 6'(d2);
		ds_k  = {ds, 10'b0} - {6'b0, ds, 4'b0} - {7'b0, ds, 3'b0};
		step  = $signed({8'b0, in_q.wall_msec}) - $signed({8'b0, prev_msec_q})
			+ $signed({2'b0, ds_k});
		msum  = {{2{ms_accum_q[19]}}, ms_accum_q} + {{4{step[17]}}, step};
		if (msum > 22'sd524287) begin
			ms_next = 20'sh7FFFF;
		end else if (msum < -22'sd524288) begin
			ms_next = 20'sh80000;
		end else begin
			ms_next = msum[19:0];
		end
		lsum = {1'b0, local_accum_q} + {5'b0, in_q.delta_time};
	end

	always_comb begin
		wdiff = wh_q[0] - {6'b0, in_q.wall_msec};
		wx    = {1'b0, wdiff} + 17'd999;
		wq8   = wprod_s1[34:27];
		wadd  = {wq8, 10'b0} - {6'b0, wq8, 4'b0} - {7'b0, wq8, 3'b0};
		w0    = {8'b0, in_q.wall_msec} + (wneed_q ? wadd : 18'd0);
		wsub  = (wh_q[PREV] > 16'd1000) ? 16'd1000 : 16'd0;
		lbase = lh_q[PREV];
	end

	always_comb begin
		idx    = KW'(LAST) - kcnt_q;
		span_a = wh_q[idx] - wh_q[LAST];
		avg    = dprod_s1[35:20];
		adev   = (avg >= {6'b0, ivl}) ? avg - {6'b0, ivl} : {6'b0, ivl} - avg;
		wspan  = wh_q[0] - wh_q[LAST];
		lspan  = lh_q[0];
		dev_ok = dev_q < DEV_W'(ivl);
		sat_hit = {18'b0, wspan, 16'b0} >= den_q;
	end

	always_comb begin
		sts.primed     = primed_q;
		sts.sample_hit = ms_accum_q >= $signed({10'b0, ivl});
		sts.dev_last   = (kcnt_q == KW'(LAST));
		sts.need_div   = dev_ok && (settle_left_q == '0) && (lspan != '0) && !sat_hit;
		sts.div_done   = drsp.done;
	end

	always_comb begin
		dreq.start    = cmd.div_ratio || cmd.div_mod;
		dreq.den      = cmd.div_ratio ? den_q : {40'b0, ivl};
		dreq.r_init   = cmd.div_ratio ? {18'b0, wspan, 16'b0} : '0;
		dreq.dividend = cmd.div_ratio ? 32'b0 : {ms_accum_q, 12'b0};
		dreq.steps    = cmd.div_ratio ? cre_pkg::RATIO_STEPS : cre_pkg::MOD_STEPS;
	end

	cre_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q     <= cre_pkg::INTERVAL_RST;
			settle_left_q  <= cre_pkg::SETTLE_RST;
			primed_q       <= 1'b0;
			prev_sec_q     <= '0;
			prev_msec_q    <= '0;
			ms_accum_q     <= '0;
			local_accum_q  <= '0;
			ratio_q        <= cre_pkg::RATIO_ONE;
			sampled_q      <= 1'b0;
			updated_q      <= 1'b0;
			kcnt_q         <= '0;
			dev_q          <= '0;
			for (int k = 0; k < HISTORY_DEPTH; k++) begin
				wh_q[k] <= '0;
				lh_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == cre_pkg::REG_INTERVAL) begin
					interval_q <= cfg_data;
				end else begin
					settle_left_q <= cfg_data[7:0];
				end
			end
			if (cmd.accept) begin
				sampled_q <= 1'b0;
				updated_q <= 1'b0;
				if (!primed_q) begin
					primed_q    <= 1'b1;
					prev_sec_q  <= tick_data.wall_sec;
					prev_msec_q <= tick_data.wall_msec;
				end
			end
			if (cmd.acc) begin
				ms_accum_q    <= ms_next;
				local_accum_q <= lsum[32] ? 32'hFFFF_FFFF : lsum[31:0];
				prev_sec_q    <= in_q.wall_sec;
				prev_msec_q   <= in_q.wall_msec;
			end
			if (cmd.shift) begin
				wh_q[0] <= w0[15:0] - wsub;
				lh_q[0] <= lh_q[0] + {8'b0, local_accum_q} - lbase;
				for (int k = 1; k < HISTORY_DEPTH; k++) begin
					wh_q[k] <= wh_q[k-1] - wsub;
					lh_q[k] <= lh_q[k-1] - lbase;
				end
				local_accum_q <= '0;
				sampled_q     <= 1'b1;
				kcnt_q        <= KW'(1);
				dev_q         <= '0;
			end
			if (cmd.deva) begin
				dev_q  <= dev_q + DEV_W'(adev);
				kcnt_q <= kcnt_q + 1'b1;
			end
			if (cmd.decide && dev_ok) begin
				if (settle_left_q != '0) begin
					settle_left_q <= settle_left_q - 1'b1;
				end else if (lspan != '0 && sat_hit) begin
					ratio_q   <= cre_pkg::RATIO_MAX;
					updated_q <= 1'b1;
				end
			end
			if (cmd.ratio_load) begin
				ratio_q   <= drsp.quo;
				updated_q <= 1'b1;
			end
			if (cmd.mod_load) begin
				ms_accum_q <= $signed({10'b0, drsp.rem[9:0]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_q <= tick_data;
		end
		if (cmd.wq) begin
			wprod_s1 <= 35'(wx) * 35'(cre_pkg::RECIP_1000);
			wneed_q  <= {6'b0, in_q.wall_msec} < wh_q[0];
		end
		if (cmd.devm) begin
			dprod_s1 <= 37'(span_a) * 37'(cre_pkg::recip(4'(kcnt_q)));
		end
		den_q <= {lspan, 10'b0} - {6'b0, lspan, 4'b0} - {7'b0, lspan, 3'b0};
		if (cmd.out_load) begin
			out_q <= '{factor: ratio_q, sample_taken: sampled_q, factor_updated: updated_q};
		end
	end

	assign result_data = out_q;

	a_upd_needs_sample: assert property (@(posedge clk) disable iff (!arst_n)
		updated_q |-> sampled_q)
		else $error("factor updated without a sample");

	a_ratio_change: assert property (@(posedge clk) disable iff (!arst_n)
		(ratio_q != $past(ratio_q)) |-> updated_q)
		else $error("factor changed without update flag");

endmodule

// ===== src/cre_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences one item through the datapath and owns the handshakes.
module cre_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tick_valid,
	output logic          tick_ready,
	output logic          res_valid,
	input  logic          res_ready,
	input  cre_pkg::sts_t sts,
	output cre_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_ACC    = 11'b000_0000_0010,
		S_WQ     = 11'b000_0000_0100,
		S_SHIFT  = 11'b000_0000_1000,
		S_DEVM   = 11'b000_0001_0000,
		S_DEVA   = 11'b000_0010_0000,
		S_DECIDE = 11'b000_0100_0000,
		S_RDIV   = 11'b000_1000_0000,
		S_MODW   = 11'b001_0000_0000,
		S_FIN    = 11'b010_0000_0000,
		S_SPARE  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (tick_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.primed ? S_ACC : S_FIN;
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_WQ;
			end
			S_WQ: begin
				cmd.wq  = 1'b1;
				state_d = sts.sample_hit ? S_SHIFT : S_FIN;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = S_DEVM;
			end
			S_DEVM: begin
				cmd.devm = 1'b1;
				state_d  = S_DEVA;
			end
			S_DEVA: begin
				cmd.deva = 1'b1;
				state_d  = sts.dev_last ? S_DECIDE : S_DEVM;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.need_div) begin
					cmd.div_ratio = 1'b1;
					state_d       = S_RDIV;
				end else begin
					cmd.div_mod = 1'b1;
					state_d     = S_MODW;
				end
			end
			S_RDIV: begin
				if (sts.div_done) begin
					cmd.ratio_load = 1'b1;
					cmd.div_mod    = 1'b1;
					state_d        = S_MODW;
				end
			end
			S_MODW: begin
				if (sts.div_done) begin
					cmd.mod_load = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || res_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign tick_ready = (state_q == S_IDLE);
	assign res_valid  = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || res_ready))
		else $error("result register overwritten");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_valid && tick_ready) |=> !tick_ready)
		else $error("second item taken while busy");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_ratio |-> sts.div_done)
		else $error("divider restarted while busy");

endmodule

// ===== src/clock_ratio_estimator_core.sv =====
`timescale 1ns / 1ps
// Top level: clock ratio estimator core.
//
// channel  dir  payload                                        accepted when
// tick     in   wall_sec, wall_msec, delta_time                valid && ready
// result   out  factor, sample_taken, factor_updated           valid && ready
// cfg      in   cfg_index (0 interval_ms, 1 settle_count)      cfg_we
//
// One item at a time. The first item after reset goes straight to the result
// register; one that does not reach the interval is accumulated first. A
// sampled item then shifts the histories and sums the deviation; the shared
// bit-serial divider then divides the factor, if needed, and the interval modulo.
// Reset is asynchronous and needs no clearing pass. A stalled result holds
// the block in its final state; the next tick is taken once the result moves.
module clock_ratio_estimator_core #(
	parameter int HISTORY_DEPTH = cre_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cre_pkg::CFG_DATA_W-1:0] cfg_data,
	cre_stream_if.sink                     tick,
	cre_stream_if.source                   result
);

	cre_pkg::cmd_t    cmd;
	cre_pkg::sts_t    sts;
	cre_pkg::tick_t   tick_data;
	cre_pkg::result_t result_data;

	assign tick_data   = tick.data;
	assign result.data = result_data;

	cre_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.tick_ready (tick.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	cre_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.tick_data   (tick_data),
		.cmd         (cmd),
		.sts         (sts),
		.result_data (result_data)
	);

endmodule
